// ===== src/sm83a_pkg.sv =====
// Shared types and constants for the SM83 ALU block.
package sm83a_pkg;

  // Operation codes.
  typedef enum logic [4:0] {
    OP_INC16  = 5'd0,
    OP_DEC16  = 5'd1,
    OP_INC8   = 5'd2,
    OP_DEC8   = 5'd3,
    OP_BIT    = 5'd4,
    OP_SET    = 5'd5,
    OP_RES    = 5'd6,
    OP_RL     = 5'd7,
    OP_RR     = 5'd8,
    OP_RLC    = 5'd9,
    OP_RRC    = 5'd10,
    OP_SLA    = 5'd11,
    OP_SRA    = 5'd12,
    OP_SRL    = 5'd13,
    OP_SWAP   = 5'd14,
    OP_ADD8   = 5'd15,
    OP_ADD16  = 5'd16,
    OP_OFFS16 = 5'd17,
    OP_SUB8   = 5'd18,
    OP_CP     = 5'd19,
    OP_AND    = 5'd20,
    OP_OR     = 5'd21,
    OP_XOR    = 5'd22
  } alu_mode_t;

  // Flag bit positions inside a 4-bit flag word / affect mask.
  localparam int unsigned FLAG_Z = 3;
  localparam int unsigned FLAG_N = 2;
  localparam int unsigned FLAG_H = 1;
  localparam int unsigned FLAG_C = 0;

  localparam logic [3:0] MASK_NONE = 4'b0000;
  localparam logic [3:0] MASK_ZNH  = 4'b1110;
  localparam logic [3:0] MASK_NHC  = 4'b0111;
  localparam logic [3:0] MASK_ALL  = 4'b1111;

  localparam logic [3:0] NIB_MAX = 4'hf;

  typedef struct packed {
    logic [4:0]        mode;
    logic [15:0]       operand_a;
    logic [15:0]       operand_b;
    logic signed [7:0] offset;
    logic [2:0]        bit_index;
    logic              carry_in;
    logic              check_zero;
  } in_item_t;

  typedef struct packed {
    logic [15:0] result;
    logic        flag_zero;
    logic        flag_subtract;
    logic        flag_half;
    logic        flag_carry;
    logic [3:0]  affect_mask;
  } out_item_t;

endpackage

// ===== src/sm83a_in_if.sv =====
// Input channel interface: valid/ready handshake with the operation fields.
interface sm83a_in_if;
  logic              valid;
  logic              ready;
  logic [4:0]        mode;
  logic [15:0]       operand_a;
  logic [15:0]       operand_b;
  logic signed [7:0] offset;
  logic [2:0]        bit_index;
  logic              carry_in;
  logic              check_zero;

  modport source (
    output valid, mode, operand_a, operand_b, offset, bit_index, carry_in, check_zero,
    input  ready
  );
  modport sink (
    input  valid, mode, operand_a, operand_b, offset, bit_index, carry_in, check_zero,
    output ready
  );
endinterface

// ===== src/sm83a_out_if.sv =====
// Result channel interface: valid/ready handshake with result and flags.
interface sm83a_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] result;
  logic        flag_zero;
  logic        flag_subtract;
  logic        flag_half;
  logic        flag_carry;
  logic [3:0]  affect_mask;

  modport source (
    output valid, result, flag_zero, flag_subtract, flag_half, flag_carry, affect_mask,
    input  ready
  );
  modport sink (
    input  valid, result, flag_zero, flag_subtract, flag_half, flag_carry, affect_mask,
    output ready
  );
endinterface

// ===== src/sm83a_alu.sv =====
// Combinational SM83 ALU datapath: result, flags and affect mask for one op.
module sm83a_alu
  import sm83a_pkg::*;
(
  input  in_item_t  item,
  output out_item_t res
);

  logic [7:0]  a8;
  logic [7:0]  b8;
  logic [7:0]  e8;
  logic        cin;
  logic        cin_sub;
  logic [7:0]  r8;
  logic [15:0] r16;
  logic        wide;
  logic        zchk;
  logic [3:0]  flags;
  logic [3:0]  mask;
  logic [3:0]  flags_all;
  logic [8:0]  add8_sum;
  logic [4:0]  add8_nib;
  logic [16:0] add16_sum;
  logic [12:0] add16_low;
  logic [4:0]  offs_nib;
  logic [8:0]  offs_byte;
  logic [8:0]  sub_diff;
  logic [4:0]  sub_nib;

  assign a8  = item.operand_a[7:0];
  assign b8  = item.operand_b[7:0];
  assign e8  = item.offset;
  assign cin = item.carry_in;
  assign cin_sub = (alu_mode_t'(item.mode) == OP_CP) ? 1'b0 : cin;

  assign add8_sum  = {1'b0, a8} + {1'b0, b8} + {8'd0, cin};
  assign add8_nib  = {1'b0, a8[3:0]} + {1'b0, b8[3:0]} + {4'd0, cin};
  assign add16_sum = {1'b0, item.operand_a} + {1'b0, item.operand_b};
  assign add16_low = {1'b0, item.operand_a[11:0]} + {1'b0, item.operand_b[11:0]};
  assign offs_nib  = {1'b0, item.operand_a[3:0]} + {1'b0, e8[3:0]};
  assign offs_byte = {1'b0, item.operand_a[7:0]} + {1'b0, e8};
  // Borrow out appears as the top bit of the widened difference.
  assign sub_diff  = {1'b0, a8} - {1'b0, b8} - {8'd0, cin_sub};
  assign sub_nib   = {1'b0, a8[3:0]} - {1'b0, b8[3:0]} - {4'd0, cin_sub};

  always_comb begin
    r8    = 8'd0;
    r16   = 16'd0;
    wide  = 1'b0;
    zchk  = 1'b0;
    flags = 4'd0;
    mask  = MASK_NONE;
    unique case (alu_mode_t'(item.mode))
      OP_INC16: begin
        wide = 1'b1;
        r16  = item.operand_a + 16'd1;
      end
      OP_DEC16: begin
        wide = 1'b1;
        r16  = item.operand_a - 16'd1;
      end
      OP_INC8: begin
        r8 = a8 + 8'd1;
        flags[FLAG_H] = (a8[3:0] == NIB_MAX);
        zchk = 1'b1;
        mask = MASK_ZNH;
      end
      OP_DEC8: begin
        r8 = a8 - 8'd1;
        flags[FLAG_N] = 1'b1;
        flags[FLAG_H] = (a8[3:0] == 4'd0);
        zchk = 1'b1;
        mask = MASK_ZNH;
      end
      OP_BIT: begin
        r8 = a8;
        flags[FLAG_H] = 1'b1;
        flags[FLAG_Z] = ~a8[item.bit_index];
        mask = MASK_ZNH;
      end
      OP_SET: r8 = a8 | (8'd1 << item.bit_index);
      OP_RES: r8 = a8 & ~(8'd1 << item.bit_index);
      OP_RL: begin
        r8 = {a8[6:0], cin};
        flags[FLAG_C] = a8[7];
        zchk = item.check_zero;
        mask = MASK_ALL;
      end
      OP_RR: begin
        r8 = {cin, a8[7:1]};
        flags[FLAG_C] = a8[0];
        zchk = item.check_zero;
        mask = MASK_ALL;
      end
      OP_RLC: begin
        r8 = {a8[6:0], a8[7]};
        flags[FLAG_C] = a8[7];
        zchk = item.check_zero;
        mask = MASK_ALL;
      end
      OP_RRC: begin
        r8 = {a8[0], a8[7:1]};
        flags[FLAG_C] = a8[0];
        zchk = item.check_zero;
        mask = MASK_ALL;
      end
      OP_SLA: begin
        r8 = {a8[6:0], 1'b0};
        flags[FLAG_C] = a8[7];
        zchk = 1'b1;
        mask = MASK_ALL;
      end
      OP_SRA: begin
        r8 = {a8[7], a8[7:1]};
        flags[FLAG_C] = a8[0];
        zchk = 1'b1;
        mask = MASK_ALL;
      end
      OP_SRL: begin
        r8 = {1'b0, a8[7:1]};
        flags[FLAG_C] = a8[0];
        zchk = 1'b1;
        mask = MASK_ALL;
      end
      OP_SWAP: begin
        r8 = {a8[3:0], a8[7:4]};
        zchk = 1'b1;
        mask = MASK_ALL;
      end
      OP_ADD8: begin
        r8 = add8_sum[7:0];
        flags[FLAG_H] = add8_nib[4];
        flags[FLAG_C] = add8_sum[8];
        zchk = 1'b1;
        mask = MASK_ALL;
      end
      OP_ADD16: begin
        wide = 1'b1;
        r16  = add16_sum[15:0];
        flags[FLAG_H] = add16_low[12];
        flags[FLAG_C] = add16_sum[16];
        mask = MASK_NHC;
      end
      OP_OFFS16: begin
        wide = 1'b1;
        r16  = item.operand_a + {{8{e8[7]}}, e8};
        flags[FLAG_H] = offs_nib[4];
        flags[FLAG_C] = offs_byte[8];
        mask = MASK_ALL;
      end
      OP_SUB8, OP_CP: begin
        r8 = (alu_mode_t'(item.mode) == OP_CP) ? a8 : sub_diff[7:0];
        flags[FLAG_N] = 1'b1;
        flags[FLAG_H] = sub_nib[4];
        flags[FLAG_C] = sub_diff[8];
        flags[FLAG_Z] = (sub_diff[7:0] == 8'd0);
        mask = MASK_ALL;
      end
      OP_AND: begin
        r8 = a8 & b8;
        flags[FLAG_H] = 1'b1;
        zchk = 1'b1;
        mask = MASK_ALL;
      end
      OP_OR: begin
        r8 = a8 | b8;
        zchk = 1'b1;
        mask = MASK_ALL;
      end
      OP_XOR: begin
        r8 = a8 ^ b8;
        zchk = 1'b1;
        mask = MASK_ALL;
      end
      default: begin
        wide = 1'b1;
        r16  = 16'd0;
      end
    endcase
  end

  always_comb begin
    flags_all = flags;
    if (zchk && (r8 == 8'd0)) begin
      flags_all[FLAG_Z] = 1'b1;
    end
    flags_all = flags_all & mask;
    res.result        = wide ? r16 : {8'd0, r8};
    res.flag_zero     = flags_all[FLAG_Z];
    res.flag_subtract = flags_all[FLAG_N];
    res.flag_half     = flags_all[FLAG_H];
    res.flag_carry    = flags_all[FLAG_C];
    res.affect_mask   = mask;
  end

endmodule

// ===== src/sm83_alu_with_flags_unit.sv =====
// Top level of the SM83 ALU: input register, ALU datapath, result register.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------------
//  in_ch   | in  | valid/ready        | mode, operand_a/b, offset, bit_index, carry_in,
//          |     |                    | check_zero
//  out_ch  | out | valid/ready        | result, flag_zero/subtract/half/carry,
//          |     |                    | affect_mask
//
// An accepted input passes the input register, then the ALU and the output register, before it is
// offered on out_ch; throughput is one transaction per cycle while out_ch is not stalled,
// set by the single ALU pass between the two registers.
// Reset (rst_n low, synchronous) empties both stages; payload regs are not reset.
// A stalled result holds in the output register; the input register keeps
// accepting as long as the output register is free or draining this cycle.
module sm83_alu_with_flags_unit
  import sm83a_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  sm83a_in_if.sink    in_ch,
  sm83a_out_if.source out_ch
);

  // Stage 1: captured input item.
  in_item_t  s1_item_r;
  logic      s1_vld_r;
  logic      s1_vld_nxt;
  // Stage 2: registered ALU result.
  out_item_t s2_item_r;
  logic      s2_vld_r;
  logic      s2_vld_nxt;

  in_item_t  in_item;
  out_item_t alu_res;
  logic      in_fire;
  logic      s2_load;
  logic      s1_adv;

  assign in_item.mode       = in_ch.mode;
  assign in_item.operand_a  = in_ch.operand_a;
  assign in_item.operand_b  = in_ch.operand_b;
  assign in_item.offset     = in_ch.offset;
  assign in_item.bit_index  = in_ch.bit_index;
  assign in_item.carry_in   = in_ch.carry_in;
  assign in_item.check_zero = in_ch.check_zero;

  // Output register can take a new result when empty or being drained.
  assign s2_load = ~s2_vld_r | out_ch.ready;
  assign s1_adv  = s1_vld_r & s2_load;
  assign in_ch.ready = ~s1_vld_r | s2_load;
  assign in_fire = in_ch.valid & in_ch.ready;

  assign s1_vld_nxt = in_fire | (s1_vld_r & ~s2_load);
  assign s2_vld_nxt = s1_adv | (s2_vld_r & ~out_ch.ready);

  sm83a_alu u_alu (
    .item (s1_item_r),
    .res  (alu_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  // Payload registers: load only on transaction, no reset needed.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      s2_item_r <= alu_res;
    end
  end

  assign out_ch.valid         = s2_vld_r;
  assign out_ch.result        = s2_item_r.result;
  assign out_ch.flag_zero     = s2_item_r.flag_zero;
  assign out_ch.flag_subtract = s2_item_r.flag_subtract;
  assign out_ch.flag_half     = s2_item_r.flag_half;
  assign out_ch.flag_carry    = s2_item_r.flag_carry;
  assign out_ch.affect_mask   = s2_item_r.affect_mask;

  // A held stage-1 item must stay put until it moves into the output register.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !s2_load) |=> (s1_vld_r && $stable(s1_item_r)))
    else $error("stage 1 item lost or changed while blocked");

  // An item moving forward always lands in the output register.
  a_s1_to_s2: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> s2_vld_r)
    else $error("advanced item missing from output register");

  // Flags outside the affect mask are always cleared.
  a_flag_mask: assert property (@(posedge clk) disable iff (!rst_n)
    s2_vld_r |-> ((~s2_item_r.affect_mask &
                   {s2_item_r.flag_zero, s2_item_r.flag_subtract,
                    s2_item_r.flag_half, s2_item_r.flag_carry}) == 4'd0))
    else $error("flag set outside affect mask");

  // Unused operation codes produce an all-zero result.
  a_unused_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (s1_item_r.mode > OP_XOR)) |=>
      ((s2_item_r.result == 16'd0) && (s2_item_r.affect_mask == MASK_NONE)))
    else $error("unused op code gave nonzero output");

endmodule
